[design/icc_pkg.sv]
// Shared types, codes and the microcode program of the impedance current controller.
`timescale 1ns / 1ps

package icc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [2:0] OP_FRAME    = 3'd0;
  localparam logic [2:0] OP_TICK     = 3'd1;
  localparam logic [2:0] OP_SETPOINT = 3'd2;
  localparam logic [2:0] OP_ZERO     = 3'd3;
  localparam logic [2:0] OP_ENABLE   = 3'd4;
  localparam logic [2:0] OP_DISABLE  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_B     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_A     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_WORD = 3'd5;

  localparam logic signed [15:0] FILTER_B_RST  = 16'sd999;
  localparam logic signed [15:0] FILTER_A_RST  = -16'sd30773;
  localparam logic [23:0]        STIFFNESS_RST = 24'd2250;
  localparam logic [23:0]        DAMPING_RST   = 24'd107136;
  localparam logic [14:0]        CUR_LIM_RST   = 15'd5000;
  localparam logic [15:0]        CTRL_WORD_RST = 16'd0;

  localparam logic signed [63:0] BIG40 = 64'sh0000_0100_0000_0000;

  typedef enum logic [1:0] {
    MA_FILT_B = 2'd0,
    MA_FILT_A = 2'd1,
    MA_STIFF  = 2'd2,
    MA_DAMP   = 2'd3
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_VSUM = 3'd0,
    MB_F_HI = 3'd1,
    MB_F_LO = 3'd2,
    MB_ERR  = 3'd3,
    MB_FH   = 3'd4,
    MB_FL   = 3'd5
  } mul_b_t;

  typedef enum logic [2:0] {
    ACC_HOLD       = 3'd0,
    ACC_LOAD_SHL24 = 3'd1,
    ACC_ADD        = 3'd2,
    ACC_SUB        = 3'd3,
    ACC_LOAD       = 3'd4,
    ACC_NEG_SHR15  = 3'd5,
    ACC_SHL15      = 3'd6
  } acc_op_t;

  typedef enum logic [2:0] {
    AUX_NONE   = 3'd0,
    AUX_REL    = 3'd1,
    AUX_VEL    = 3'd2,
    AUX_SUM    = 3'd3,
    AUX_COMMIT = 3'd4,
    AUX_FINISH = 3'd5
  } aux_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_FINISH = pc_t'(10);

  typedef struct packed {
    logic    mul_en;
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    acc_op_t acc_op;
    aux_t    aux;
    logic    jmp_big;
    pc_t     target;
    logic    last;
  } ucode_t;

  function automatic ucode_t uc(input logic mul_en, input mul_a_t ma, input mul_b_t mb,
                                input acc_op_t op, input aux_t aux, input logic jmp,
                                input pc_t tgt, input logic last);
    ucode_t w;
    w.mul_en  = mul_en;
    w.mul_a   = ma;
    w.mul_b   = mb;
    w.acc_op  = op;
    w.aux     = aux;
    w.jmp_big = jmp;
    w.target  = tgt;
    w.last    = last;
    return w;
  endfunction

  // one control word per step of the tick program
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      pc_t'(0):  w = uc(1'b1, MA_FILT_A, MB_F_HI, ACC_HOLD,       AUX_REL,    1'b0, '0, 1'b0);
      pc_t'(1):  w = uc(1'b1, MA_FILT_A, MB_F_LO, ACC_LOAD_SHL24, AUX_VEL,    1'b0, '0, 1'b0);
      pc_t'(2):  w = uc(1'b0, MA_FILT_B, MB_VSUM, ACC_ADD,        AUX_SUM,    1'b0, '0, 1'b0);
      pc_t'(3):  w = uc(1'b1, MA_FILT_B, MB_VSUM, ACC_NEG_SHR15,  AUX_NONE,   1'b0, '0, 1'b0);
      pc_t'(4):  w = uc(1'b0, MA_FILT_B, MB_VSUM, ACC_ADD,        AUX_NONE,   1'b0, '0, 1'b0);
      pc_t'(5):  w = uc(1'b1, MA_STIFF,  MB_ERR,  ACC_HOLD,       AUX_COMMIT, 1'b0, '0, 1'b0);
      pc_t'(6):  w = uc(1'b1, MA_DAMP,   MB_FH,   ACC_LOAD,       AUX_NONE,   1'b0, '0, 1'b0);
      pc_t'(7):  w = uc(1'b1, MA_DAMP,   MB_FL,   ACC_SUB,        AUX_NONE,   1'b0, '0, 1'b0);
      pc_t'(8):  w = uc(1'b0, MA_DAMP,   MB_FL,   ACC_SHL15,      AUX_NONE,   1'b1,
                        PC_FINISH, 1'b0);
      pc_t'(9):  w = uc(1'b0, MA_DAMP,   MB_FL,   ACC_SUB,        AUX_NONE,   1'b0, '0, 1'b0);
      PC_FINISH: w = uc(1'b0, MA_DAMP,   MB_FL,   ACC_HOLD,       AUX_FINISH, 1'b0, '0, 1'b1);
      default:   w = uc(1'b0, MA_DAMP,   MB_FL,   ACC_HOLD,       AUX_NONE,   1'b0, '0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

[design/icc_if.sv]
// Valid/ready channel interfaces for event input and current command output.
`timescale 1ns / 1ps

interface icc_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic signed [31:0] raw_position;
  logic [15:0]       drive_status;
  logic signed [31:0] target_position;

  modport source (output valid, output opcode, output raw_position, output drive_status,
                  output target_position, input ready);
  modport sink (input valid, input opcode, input raw_position, input drive_status,
                input target_position, output ready);
endinterface

interface icc_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] current_command;
  logic [15:0]       control_word_out;
  logic              fault_seen;
  logic              control_active;

  modport source (output valid, output current_command, output control_word_out,
                  output fault_seen, output control_active, input ready);
  modport sink (input valid, input current_command, input control_word_out,
                input fault_seen, input control_active, output ready);
endinterface

[design/icc_seq.sv]
// Microcode sequencer: step counter, program ROM and conditional jump.
`timescale 1ns / 1ps

module icc_seq
  import icc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  logic   big,
  input  logic   hold,
  output ucode_t cw,
  output logic   busy,
  output logic   fire
);

  pc_t  pc;
  pc_t  pc_next;
  logic busy_next;

  assign cw   = ucode_rom(pc);
  assign fire = busy && !(cw.last && hold);

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (!busy) begin
      if (start) begin
        busy_next = 1'b1;
        pc_next   = '0;
      end
    end else if (cw.last) begin
      if (!hold) begin
        busy_next = 1'b0;
      end
    end else if (cw.jmp_big && big) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

endmodule

[design/impedance_current_controller_core.sv]
// Top level of the impedance current controller: event handling and tick datapath.
`timescale 1ns / 1ps
//
// Events arrive on in_ch (valid/ready); a transaction is taken when both are high.
// Frame, setpoint, zero capture, enable and disable take effect at the accepting
// edge and give no result; opcodes 6 and 7 are dropped.
// A tick runs an 11-step microcode program on one shared 25x34 multiplier and a
// 64-bit accumulator (10 steps when the law saturates). in_ch.ready is low while
// it runs; out_ch.valid rises at the edge that ends the last step, and in_ch.ready
// returns high at that same edge.
// The result sits in an output register until taken on out_ch; new events are
// still accepted meanwhile. If a further tick finishes while that register is
// still held, the program waits on its last step until out_ch.ready.
// The user writes registers through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// rst (synchronous) restores register defaults, clears the event latches and the
// filter history, turns control off, idles the sequencer and empties the output register.
//
module impedance_current_controller_core
  import icc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  icc_in_if.sink                in_ch,
  icc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic signed [15:0] filter_b;
  logic signed [15:0] filter_a;
  logic [23:0]        stiffness_gain;
  logic [23:0]        damping_gain;
  logic [14:0]        current_limit;
  logic [15:0]        drive_control_word;

  logic signed [31:0] position_now;
  logic signed [31:0] position_before;
  logic signed [32:0] velocity_before;
  logic signed [47:0] filtered_before;
  logic signed [31:0] zero_offset;
  logic [15:0]        status_latch;
  logic signed [31:0] setpoint_latch;
  logic               active_flag;

  logic signed [31:0] rel_r;
  logic signed [32:0] vel_r;
  logic signed [32:0] err_r;
  logic signed [33:0] vsum_r;

  logic signed [24:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [58:0] prod;
  logic signed [63:0] prod64;
  logic signed [63:0] acc;
  logic               big_pos;
  logic               big_neg;
  logic               big_pos_now;
  logic               big_neg_now;
  logic [47:0]        filt_sat;

  logic               out_valid;
  logic signed [15:0] cur_q;
  logic [15:0]        ctrl_q;
  logic               fault_q;
  logic               active_q;

  logic               accept;
  logic               start;
  logic               busy;
  logic               fire;
  logic               hold;
  ucode_t             cw;

  logic               fault;
  logic               active_next;
  logic signed [41:0] cur_raw;
  logic signed [41:0] lim42;
  logic signed [15:0] cur_next;

  assign accept = in_ch.valid && in_ch.ready;
  assign start  = accept && (in_ch.opcode == OP_TICK);
  assign hold   = out_valid && !out_ch.ready;
  assign in_ch.ready = !busy;

  icc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .big   (big_pos_now || big_neg_now),
    .hold  (hold),
    .cw    (cw),
    .busy  (busy),
    .fire  (fire)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_b           <= FILTER_B_RST;
      filter_a           <= FILTER_A_RST;
      stiffness_gain     <= STIFFNESS_RST;
      damping_gain       <= DAMPING_RST;
      current_limit      <= CUR_LIM_RST;
      drive_control_word <= CTRL_WORD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_B:     filter_b           <= cfg_data[15:0];
        REG_FILTER_A:     filter_a           <= cfg_data[15:0];
        REG_STIFFNESS:    stiffness_gain     <= cfg_data[23:0];
        REG_DAMPING:      damping_gain       <= cfg_data[23:0];
        REG_CURRENT_LIM:  current_limit      <= cfg_data[14:0];
        REG_CONTROL_WORD: drive_control_word <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (cw.mul_a)
      MA_FILT_B: mul_a = {{9{filter_b[15]}}, filter_b};
      MA_FILT_A: mul_a = {{9{filter_a[15]}}, filter_a};
      MA_STIFF:  mul_a = {1'b0, stiffness_gain};
      MA_DAMP:   mul_a = {1'b0, damping_gain};
      default:   mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (cw.mul_b)
      MB_VSUM: mul_b = vsum_r;
      MB_F_HI: mul_b = {{10{filtered_before[47]}}, filtered_before[47:24]};
      MB_F_LO: mul_b = {10'b0, filtered_before[23:0]};
      MB_ERR:  mul_b = {err_r[32], err_r};
      MB_FH:   mul_b = {filtered_before[47], filtered_before[47:15]};
      MB_FL:   mul_b = {19'b0, filtered_before[14:0]};
      default: mul_b = '0;
    endcase
  end

  assign prod64      = {{5{prod[58]}}, prod};
  assign big_pos_now = acc > BIG40;
  assign big_neg_now = acc < -BIG40;
  assign filt_sat    = (acc[63:47] == {17{acc[47]}}) ? acc[47:0] :
                       (acc[63] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}});

  always_ff @(posedge clk) begin
    if (fire && cw.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (fire) begin
      unique case (cw.acc_op)
        ACC_HOLD:       acc <= acc;
        ACC_LOAD_SHL24: acc <= prod64 <<< 24;
        ACC_ADD:        acc <= acc + prod64;
        ACC_SUB:        acc <= acc - prod64;
        ACC_LOAD:       acc <= prod64;
        ACC_NEG_SHR15:  acc <= -(acc >>> 15);
        ACC_SHL15: begin
          acc     <= acc <<< 15;
          big_pos <= big_pos_now;
          big_neg <= big_neg_now;
        end
        default:        acc <= acc;
      endcase
    end
  end

  // current from the scaled law, rounded toward zero, then forced and clamped
  assign fault       = status_latch[3];
  assign active_next = active_flag && !fault;
  assign cur_raw     = {acc[63], acc[63:23]} + 42'(acc[63] && (acc[22:0] != '0));
  assign lim42       = {27'b0, current_limit};

  always_comb begin
    priority if (!active_next) begin
      cur_next = '0;
    end else if (big_pos || (!big_neg && cur_raw > lim42)) begin
      cur_next = {1'b0, current_limit};
    end else if (big_neg || cur_raw < -lim42) begin
      cur_next = -{1'b0, current_limit};
    end else begin
      cur_next = cur_raw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      unique case (cw.aux)
        AUX_REL: rel_r <= position_now - zero_offset;
        AUX_VEL: begin
          vel_r <= {rel_r[31], rel_r} - {position_before[31], position_before};
          err_r <= {setpoint_latch[31], setpoint_latch} - {rel_r[31], rel_r};
        end
        AUX_SUM: vsum_r <= {vel_r[32], vel_r} + {velocity_before[32], velocity_before};
        default: ;
      endcase
    end
    if (fire && cw.aux == AUX_FINISH) begin
      cur_q    <= cur_next;
      ctrl_q   <= drive_control_word;
      fault_q  <= fault;
      active_q <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_now    <= '0;
      position_before <= '0;
      velocity_before <= '0;
      filtered_before <= '0;
      zero_offset     <= '0;
      status_latch    <= '0;
      setpoint_latch  <= '0;
      active_flag     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        unique case (in_ch.opcode)
          OP_FRAME: begin
            position_now <= in_ch.raw_position;
            status_latch <= in_ch.drive_status;
          end
          OP_SETPOINT: setpoint_latch <= in_ch.target_position;
          OP_ZERO:     zero_offset    <= position_now;
          OP_ENABLE:   active_flag    <= 1'b1;
          OP_DISABLE:  active_flag    <= 1'b0;
          default: ;
        endcase
      end
      if (fire && cw.aux == AUX_COMMIT) begin
        filtered_before <= filt_sat;
        velocity_before <= vel_r;
        position_before <= rel_r;
      end
      if (fire && cw.aux == AUX_FINISH) begin
        active_flag <= active_next;
        out_valid   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.current_command  = cur_q;
  assign out_ch.control_word_out = ctrl_q;
  assign out_ch.fault_seen       = fault_q;
  assign out_ch.control_active   = active_q;

endmodule

[tb/impedance_current_controller_core_test.sv]
// Self-checking testbench for the impedance current controller core.
`timescale 1ns / 1ps

module impedance_current_controller_core_test;
  import icc_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int     TICK_CYCLES = 14;
  localparam int     HOLD_CYCLES = 200;
  localparam int     STALL_LIMIT = 2000;
  localparam longint FILT_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint FILT_MIN    = -FILT_MAX - 1;
  localparam longint LAW_SAT     = 64'sh0000_0100_0000_0000;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] raw_position;
    logic [15:0]        drive_status;
    logic signed [31:0] target_position;
  } drive_evt_t;

  typedef struct packed {
    logic signed [15:0] current_command;
    logic [15:0]        control_word_out;
    logic               fault_seen;
    logic               control_active;
  } drive_cmd_t;

  typedef struct packed {
    logic signed [15:0] filt_b;
    logic signed [15:0] filt_a;
    logic [23:0]        stiffness;
    logic [23:0]        damping;
    logic [14:0]        cur_limit;
    logic [15:0]        ctrl_word;
  } gains_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  icc_in_if  in_ch();
  icc_out_if out_ch();

  impedance_current_controller_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // controller state as the predictor sees it
  gains_t             gains;
  logic signed [31:0] enc_count;
  logic signed [31:0] zero_count;
  logic signed [31:0] setpoint;
  logic [15:0]        status_word;
  logic               ctrl_on;
  longint             rel_prev;
  longint             vel_prev;
  longint             filt_prev;

  drive_cmd_t expected_cmds[$];
  drive_cmd_t due_cmd;

  bit burst       = 1'b0;
  bit hold_output = 1'b0;
  int n_errors      = 0;
  int n_events      = 0;
  int n_checked     = 0;
  int n_fault_ticks = 0;
  int n_settings    = 0;
  int stall_cycles  = 0;

  function automatic int draw_gap();
    return burst ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic drive_evt_t mk(input logic [2:0] op, input logic [31:0] raw,
                                    input logic [15:0] status, input logic [31:0] target);
    drive_evt_t ev;
    ev.opcode          = op;
    ev.raw_position    = raw;
    ev.drive_status    = status;
    ev.target_position = target;
    return ev;
  endfunction

  function automatic drive_evt_t junk_evt(input logic [2:0] op);
    return mk(op, $urandom, 16'($urandom), $urandom);
  endfunction

  function automatic drive_evt_t next_frame();
    drive_evt_t ev;
    ev = junk_evt(OP_FRAME);
    if ($urandom_range(0, 99) != 0)
      ev.raw_position = enc_count + (int'($urandom_range(0, 20)) - 10);
    ev.drive_status = ev.drive_status & ~16'h0008;
    if ($urandom_range(0, 11) == 0)
      ev.drive_status = ev.drive_status | 16'h0008;
    return ev;
  endfunction

  function automatic gains_t random_gains(input bit wild);
    gains_t g;
    if (wild) begin
      g.filt_b    = 16'($urandom);
      g.filt_a    = 16'($urandom);
      g.stiffness = 24'($urandom);
      g.damping   = 24'($urandom);
      g.cur_limit = 15'($urandom);
    end else begin
      g.filt_b    = 16'($urandom_range(0, 4000));
      g.filt_a    = 16'(-int'($urandom_range(28000, 32768)));
      g.stiffness = 24'($urandom_range(0, 20000));
      g.damping   = 24'($urandom_range(0, 300000));
      g.cur_limit = 15'($urandom_range(200, 32767));
    end
    g.ctrl_word = 16'($urandom);
    return g;
  endfunction

  task automatic reset_predictor();
    gains = {FILTER_B_RST, FILTER_A_RST, STIFFNESS_RST, DAMPING_RST, CUR_LIM_RST,
             CTRL_WORD_RST};
    enc_count   = '0;
    zero_count  = '0;
    setpoint    = '0;
    status_word = '0;
    ctrl_on     = 1'b0;
    rel_prev    = 0;
    vel_prev    = 0;
    filt_prev   = 0;
  endtask

  task automatic update_controller(input drive_evt_t ev);
    logic signed [31:0] rel32;
    longint rel, vel, filt, err, acc, cur, f_lo, f_hi;
    longint k_b, k_a, k_stiff, k_damp, k_lim;
    logic fault;
    drive_cmd_t cmd;
    k_b     = longint'(signed'(gains.filt_b));
    k_a     = longint'(signed'(gains.filt_a));
    k_stiff = gains.stiffness;
    k_damp  = gains.damping;
    k_lim   = gains.cur_limit;
    case (ev.opcode)
      OP_FRAME: begin
        enc_count   = ev.raw_position;
        status_word = ev.drive_status;
      end
      OP_SETPOINT: setpoint = ev.target_position;
      OP_ZERO:     zero_count = enc_count;
      OP_ENABLE:   ctrl_on = 1'b1;
      OP_DISABLE:  ctrl_on = 1'b0;
      OP_TICK: begin
        rel32 = enc_count - zero_count;
        rel   = rel32;
        vel   = rel - rel_prev;
        filt  = k_b * (vel + vel_prev) - ((k_a * filt_prev) >>> 15);
        if (filt > FILT_MAX)
          filt = FILT_MAX;
        else if (filt < FILT_MIN)
          filt = FILT_MIN;
        vel_prev  = vel;
        filt_prev = filt;
        rel_prev  = rel;
        err  = longint'(setpoint) - rel;
        f_lo = filt & 64'sh7FFF;
        f_hi = filt >>> 15;
        acc  = k_stiff * err - k_damp * f_hi;
        if (acc > LAW_SAT)
          cur = LAW_SAT;
        else if (acc < -LAW_SAT)
          cur = -LAW_SAT;
        else
          cur = (acc * 32768 - k_damp * f_lo) / 8388608;
        fault = status_word[3];
        if (fault) begin
          ctrl_on = 1'b0;
          n_fault_ticks++;
        end
        if (fault || !ctrl_on)
          cur = 0;
        if (cur > k_lim)
          cur = k_lim;
        if (cur < -k_lim)
          cur = -k_lim;
        cmd.current_command  = 16'(cur);
        cmd.control_word_out = gains.ctrl_word;
        cmd.fault_seen       = fault;
        cmd.control_active   = ctrl_on;
        expected_cmds.push_back(cmd);
      end
      default: ;
    endcase
  endtask

  // one transaction per call; valid stays high when the next one follows at once
  task automatic send_event(input drive_evt_t ev);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.opcode          <= ev.opcode;
    in_ch.raw_position    <= ev.raw_position;
    in_ch.drive_status    <= ev.drive_status;
    in_ch.target_position <= ev.target_position;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    update_controller(ev);
    n_events++;
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (expected_cmds.size() != 0)
      @(posedge clk);
  endtask

  task automatic settle();
    wait_all_results();
    repeat (TICK_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // unused upper data bits carry noise; the block must ignore them
  task automatic load_config(input gains_t g);
    write_reg(REG_FILTER_B, {8'($urandom), g.filt_b});
    write_reg(REG_FILTER_A, {8'($urandom), g.filt_a});
    write_reg(REG_STIFFNESS, g.stiffness);
    write_reg(REG_DAMPING, g.damping);
    write_reg(REG_CURRENT_LIM, {9'($urandom), g.cur_limit});
    write_reg(REG_CONTROL_WORD, {8'($urandom), g.ctrl_word});
    cfg_we <= 1'b0;
    gains = g;
    n_settings++;
  endtask

  task automatic run_traffic(input int n_items);
    int sent;
    int pick;
    drive_evt_t ev;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (!ctrl_on && pick < 20) begin
        send_event(junk_evt(OP_ENABLE));
        sent++;
      end else if (pick < 60) begin
        send_event(next_frame());
        send_event(junk_evt(OP_TICK));
        sent += 2;
      end else if (pick < 68) begin
        ev = junk_evt(OP_SETPOINT);
        if ($urandom_range(0, 6) != 0)
          ev.target_position = enc_count - zero_count + (int'($urandom_range(0, 1200)) - 600);
        send_event(ev);
        sent++;
      end else if (pick < 72) begin
        send_event(junk_evt(OP_ZERO));
        sent++;
      end else if (pick < 78) begin
        send_event(junk_evt(OP_ENABLE));
        sent++;
      end else if (pick < 81) begin
        send_event(junk_evt(OP_DISABLE));
        sent++;
      end else if (pick < 86) begin
        send_event(junk_evt($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO));
      end else if (pick < 93) begin
        send_event(junk_evt(OP_TICK));
        sent++;
      end else begin
        send_event(next_frame());
        sent++;
      end
    end
  endtask

  // zero coefficients empty the filter history in one tick
  task automatic flush_filter();
    gains_t g;
    drive_evt_t ev;
    g = gains;
    g.filt_b = '0;
    g.filt_a = '0;
    load_config(g);
    ev = junk_evt(OP_FRAME);
    ev.raw_position = enc_count;
    ev.drive_status = ev.drive_status & ~16'h0008;
    send_event(ev);
    send_event(junk_evt(OP_TICK));
    send_event(junk_evt(OP_TICK));
    settle();
  endtask

  task automatic test_directed_cases();
    send_event(mk(OP_TICK, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_FRAME, 32'h7FFF_FFFF, 16'h0000, 32'h0));
    send_event(mk(OP_SETPOINT, 32'h0, 16'h0, 32'h8000_0000));
    send_event(mk(OP_ENABLE, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_event(mk(OP_ZERO, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_FRAME, 32'h8000_0000, 16'hFFF7, 32'h0));
    send_event(mk(OP_SETPOINT, 32'h0, 16'h0, 32'h7FFF_FFFF));
    send_event(mk(OP_TICK, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_SPARE_LO, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_event(mk(OP_SPARE_HI, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_FRAME, 32'h0, 16'hFFFF, 32'h0));
    send_event(mk(OP_TICK, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_TICK, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_FRAME, 32'd100, 16'h0000, 32'h0));
    send_event(mk(OP_ENABLE, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_ZERO, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_SETPOINT, 32'h0, 16'h0, 32'd200));
    send_event(mk(OP_TICK, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_DISABLE, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_TICK, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_ENABLE, 32'h0, 16'h0, 32'h0));
    send_event(mk(OP_FRAME, 32'd105, 16'h0001, 32'h0));
    send_event(mk(OP_TICK, 32'h0, 16'h0, 32'h0));
    settle();
  endtask

  task automatic test_register_extremes();
    load_config({16'sh7FFF, 16'sh7FFF, 24'hFF_FFFF, 24'hFF_FFFF, 15'h7FFF, 16'hFFFF});
    run_traffic(30);
    settle();
    load_config({16'sh8000, 16'sh8000, 24'h0, 24'h0, 15'h0, 16'h0000});
    run_traffic(25);
    settle();
    load_config({16'sh8000, 16'sh8000, 24'hFF_FFFF, 24'h0, 15'h7FFF, 16'h5A5A});
    run_traffic(30);
    settle();
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 5; k++) begin
      flush_filter();
      load_config(random_gains(k == 4));
      burst = ($urandom_range(0, 2) == 0);
      run_traffic(50);
      burst = 1'b0;
      settle();
    end
  endtask

  task automatic test_output_backpressure();
    send_event(junk_evt(OP_ENABLE));
    hold_output = 1'b1;
    burst = 1'b1;
    repeat (12) begin
      send_event(next_frame());
      send_event(junk_evt(OP_TICK));
    end
    burst = 1'b0;
    wait_all_results();
  endtask

  task automatic test_sender_pause();
    repeat (4) begin
      run_traffic(15);
      wait_all_results();
    end
  endtask

  initial begin
    rst                   <= 1'b1;
    in_ch.valid           <= 1'b0;
    in_ch.opcode          <= OP_FRAME;
    in_ch.raw_position    <= '0;
    in_ch.drive_status    <= '0;
    in_ch.target_position <= '0;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_FILTER_B;
    cfg_data              <= '0;
    reset_predictor();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_register_extremes();
    test_random_settings();
    test_output_backpressure();
    test_sender_pause();

    wait_all_results();
    repeat (TICK_CYCLES) @(posedge clk);
    $display("Run: %0d events accepted, %0d drive commands checked (%0d under drive fault)",
             n_events, n_checked, n_fault_ticks);
    $display("     across %0d register settings, with output hold-off and sender pauses",
             n_settings);
    if (n_errors == 0 && expected_cmds.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    forever begin
      if (hold_output) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!(out_ch.valid && out_ch.ready) && !hold_output);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_cmds.size() == 0) begin
        $error("drive command with none pending: current_command %0d", out_ch.current_command);
        n_errors++;
      end else begin
        due_cmd = expected_cmds.pop_front();
        n_checked++;
        if (out_ch.current_command !== due_cmd.current_command) begin
          $error("current_command: expected %0d, got %0d",
                 due_cmd.current_command, out_ch.current_command);
          n_errors++;
        end
        if (out_ch.control_word_out !== due_cmd.control_word_out) begin
          $error("control_word_out: expected 0x%04h, got 0x%04h",
                 due_cmd.control_word_out, out_ch.control_word_out);
          n_errors++;
        end
        if (out_ch.fault_seen !== due_cmd.fault_seen) begin
          $error("fault_seen: expected %0b, got %0b", due_cmd.fault_seen, out_ch.fault_seen);
          n_errors++;
        end
        if (out_ch.control_active !== due_cmd.control_active) begin
          $error("control_active: expected %0b, got %0b",
                 due_cmd.control_active, out_ch.control_active);
          n_errors++;
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d commands outstanding",
               STALL_LIMIT, expected_cmds.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
